@@ design/upd_pkg.sv @@
// Shared types, constants and helper functions for the URL percent decoder.
// No dependencies; every other design file refers to this package by scoped names.
package upd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned MAX_OUT         = 3;
    localparam int unsigned CNT_W           = $clog2(MAX_OUT + 1);
    localparam int unsigned NIB_W           = 4;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Escape phase of the front end.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // All decoded bytes that one input transaction produces, lowest index first.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    str_last;
    } t_bundle;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // Valid only for hex digit characters: letters have bit 6 set.
    function automatic logic [NIB_W-1:0] hex_val(input logic [7:0] c);
        return c[6] ? (c[NIB_W-1:0] + 4'd9) : c[NIB_W-1:0];
    endfunction

endpackage

@@ design/upd_front.sv @@
// Front end of the URL percent decoder: accepts encoded bytes, tracks the
// escape phase and builds one bundle of decoded bytes per transaction. Uses upd_pkg.
module upd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  upd_pkg::t_q_status i_q_stat,
    output logic             o_push,
    output upd_pkg::t_bundle o_bundle
);

    upd_pkg::t_phase r_phase, n_phase, mid_phase;
    logic [7:0]      r_held, n_held;
    logic            accept;
    logic            c_hex;
    logic            c_pct;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign c_hex   = upd_pkg::hex_ok(i_byte);
    assign c_pct   = (i_byte == upd_pkg::PCT_CHAR);

    // Next state: mid_phase is the phase after the byte itself, before end-of-string flush.
    always_comb begin
        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (c_hex) mid_phase = upd_pkg::PH_DIGIT;
                else       mid_phase = c_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
            end
            upd_pkg::PH_DIGIT: begin
                if (c_hex) mid_phase = upd_pkg::PH_IDLE;
                else       mid_phase = c_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
            end
            default: begin
                mid_phase = c_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
            end
        endcase

        n_phase = r_phase;
        n_held  = r_held;
        if (accept) begin
            n_phase = i_last ? upd_pkg::PH_IDLE : mid_phase;
            if (r_phase == upd_pkg::PH_PCT && c_hex) n_held = i_byte;
            if (i_last) n_held = '0;
        end
    end

    // Outputs: assemble the bundle of decoded bytes in emission order.
    always_comb begin
        logic [upd_pkg::CNT_W-1:0] cnt;
        logic [7:0]                hi_held;
        cnt      = '0;
        o_bundle = '0;
        hi_held  = (r_phase == upd_pkg::PH_PCT) ? i_byte : r_held;

        case (r_phase)
            upd_pkg::PH_PCT: begin
                if (!c_hex) begin
                    o_bundle.bytes[cnt] = upd_pkg::PCT_CHAR;
                    cnt = cnt + 1'b1;
                    if (!c_pct) begin
                        o_bundle.bytes[cnt] = i_byte;
                        cnt = cnt + 1'b1;
                    end
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (c_hex) begin
                    o_bundle.bytes[cnt] = {upd_pkg::hex_val(r_held), upd_pkg::hex_val(i_byte)};
                    cnt = cnt + 1'b1;
                end else begin
                    o_bundle.bytes[cnt] = upd_pkg::PCT_CHAR;
                    cnt = cnt + 1'b1;
                    o_bundle.bytes[cnt] = r_held;
                    cnt = cnt + 1'b1;
                    if (!c_pct) begin
                        o_bundle.bytes[cnt] = i_byte;
                        cnt = cnt + 1'b1;
                    end
                end
            end
            default: begin
                if (!c_pct) begin
                    o_bundle.bytes[cnt] = i_byte;
                    cnt = cnt + 1'b1;
                end
            end
        endcase

        // An escape cut short by the end of the string goes out literally.
        if (i_last) begin
            if (mid_phase == upd_pkg::PH_PCT) begin
                o_bundle.bytes[cnt] = upd_pkg::PCT_CHAR;
                cnt = cnt + 1'b1;
            end else if (mid_phase == upd_pkg::PH_DIGIT) begin
                o_bundle.bytes[cnt] = upd_pkg::PCT_CHAR;
                cnt = cnt + 1'b1;
                o_bundle.bytes[cnt] = hi_held;
                cnt = cnt + 1'b1;
            end
        end

        o_bundle.count    = cnt;
        o_bundle.str_last = i_last;
        o_push            = accept && (cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_held  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    // The end of a string always leaves the decoder idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_phase == upd_pkg::PH_IDLE))
        else $error("phase not idle after final byte");

    // A final byte always yields at least one decoded byte.
    a_last_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |-> o_push)
        else $error("final byte produced no output");

endmodule

@@ design/upd_queue.sv @@
// Short bundle queue between the front and back ends of the URL percent decoder.
// Uses upd_pkg; DEPTH must be a power of two, at least 2.
module upd_queue #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  upd_pkg::t_bundle   i_data,
    input  logic               i_pop,
    output upd_pkg::t_bundle   o_data,
    output upd_pkg::t_q_status o_stat
);

    localparam int unsigned AW = $clog2(DEPTH);

    upd_pkg::t_bundle r_mem [DEPTH];
    logic [AW:0]      r_wr, n_wr;
    logic [AW:0]      r_rd, n_rd;

    assign o_stat.not_empty = (r_wr != r_rd);
    assign o_stat.full      = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_data           = r_mem[r_rd[AW-1:0]];

    assign n_wr = i_push ? (r_wr + 1'b1) : r_wr;
    assign n_rd = i_pop  ? (r_rd + 1'b1) : r_rd;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

endmodule

@@ design/upd_back.sv @@
// Back end of the URL percent decoder: walks each queued bundle one byte at a
// time into the output register. Uses upd_pkg.
module upd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  upd_pkg::t_bundle   i_data,
    input  upd_pkg::t_q_status i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_byte,
    output logic               o_run_last,
    output logic               o_str_last
);

    logic [upd_pkg::CNT_W-1:0] r_idx, n_idx;
    logic                      r_valid, n_valid;
    logic [7:0]                r_byte;
    logic                      r_run_last;
    logic                      r_str_last;
    logic                      load;
    logic                      at_end;

    assign load   = i_q_stat.not_empty && (!r_valid || i_ready);
    assign at_end = (r_idx == (i_data.count - 1'b1));
    assign o_pop  = load && at_end;

    assign n_idx   = load ? (at_end ? '0 : (r_idx + 1'b1)) : r_idx;
    assign n_valid = load ? 1'b1 : (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= i_data.bytes[r_idx];
            r_run_last <= at_end;
            r_str_last <= at_end && i_data.str_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_run_last = r_run_last;
    assign o_str_last = r_str_last;

    // The byte index never runs past the bundle at the queue head.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.not_empty |-> (r_idx < i_data.count))
        else $error("byte index beyond bundle");

    // The end of a string is always the end of a run.
    a_str_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_str_last) |-> r_run_last)
        else $error("string end not marked as run end");

endmodule

@@ design/url_percent_decoder_top.sv @@
// Top level of the streaming URL percent decoder.
// Instantiates upd_front, upd_queue and upd_back; types and constants come from upd_pkg.
//
// The decoder takes one encoded string byte per transaction on the slave stream
// (tlast marks the final byte of the string) and delivers the decoded bytes on the
// master stream. A percent sign followed by two hex digits (0-9, A-F, a-f) becomes
// one byte, high digit first; a percent sign that is not followed by two hex digits
// is passed on literally, together with any digit already seen, and the breaking
// byte is then handled afresh, so it may open a new escape. Anything still pending
// when the final byte arrives is flushed. Each input byte yields zero to three
// output bytes: tuser marks the last output byte caused by one input byte, and
// tlast marks the final decoded byte of the string. The front end accepts one byte
// every cycle as long as the bundle queue (QUEUE_DEPTH entries) has room, and the
// back end delivers one decoded byte every cycle the sink is ready, so the queue
// absorbs the burst of a broken escape that produces two or three bytes. The
// bundle of an input byte is written into the queue when the input transaction
// completes and is then loaded from the queue head into the output register.
// No reset sweep is needed.
module url_percent_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Encoded input stream.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // in_last
    // Decoded output stream.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] run_last
    output logic       o_m_axis_tlast    // string_last
);

    upd_pkg::t_bundle   push_data;
    upd_pkg::t_bundle   head_data;
    upd_pkg::t_q_status q_stat;
    logic               push;
    logic               pop;

    // Front end: phase tracking and bundle assembly, one transaction per cycle while the queue has room.
    upd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_bundle (push_data)
    );

    // Queue decouples the input rate from the variable output burst length.
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_stat  (q_stat)
    );

    // Back end: serializes bundles into the registered output stage.
    upd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (head_data),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_byte     (o_m_axis_tdata),
        .o_run_last (o_m_axis_tuser),
        .o_str_last (o_m_axis_tlast)
    );

endmodule

@@ tb/tb_url_percent_decoder_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for url_percent_decoder_top: it streams encoded strings in,
// predicts the decoded bytes and compares every output transaction against them.
// Depends on upd_pkg and the decoder RTL only.
module tb_url_percent_decoder_top;

    localparam int          CLK_HALF_NS    = 5;
    localparam int          RESET_CYCLES   = 3;
    localparam int          MAX_GAP        = 8;
    localparam int          RANDOM_ITEMS   = 380;
    localparam int          MAX_STR_TOKENS = 8;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          FLOOD_ITEMS    = 40;
    localparam int          SETTLE_CYCLES  = 10;
    localparam int          DRAIN_LIMIT    = 5000;
    localparam int          REPORT_LIMIT   = 10;
    localparam longint      RUN_LIMIT_NS   = 2_000_000;
    localparam int          NOT_HEX        = -1;

    localparam logic [7:0]  CH_0  = "0";
    localparam logic [7:0]  CH_9  = "9";
    localparam logic [7:0]  CH_UA = "A";
    localparam logic [7:0]  CH_UF = "F";
    localparam logic [7:0]  CH_LA = "a";
    localparam logic [7:0]  CH_LF = "f";

    // One decoded byte as it should leave the master stream.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_last;
    } t_dec_out;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] in_byte
    logic       i_s_axis_tlast;   // in_last
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [7:0] out_byte
    logic       o_m_axis_tuser;   // [0] run_last
    logic       o_m_axis_tlast;   // string_last

    // Shadow copy of the decoder's escape state.
    upd_pkg::t_phase dec_phase;
    logic [7:0]      dec_held;

    t_dec_out   decoded_q[$];
    int         fail_count;
    bit         gaps_enabled;
    int         sink_hold_req;

    url_percent_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return NOT_HEX;
    endfunction

    // Advances the shadow state by one accepted input byte and queues the decoded
    // bytes it releases, flagging the last one of the run and of the string.
    function automatic void predict_decode(input logic [7:0] c, input logic last);
        logic [7:0] outs [3];
        int         n;
        int         v;
        int         hi;
        bit         reopen;
        t_dec_out   item;
        n      = 0;
        v      = hex_digit_value(c);
        reopen = 1'b0;
        case (dec_phase)
            upd_pkg::PH_PCT: begin
                if (v != NOT_HEX) begin
                    dec_held  = c;
                    dec_phase = upd_pkg::PH_DIGIT;
                end else begin
                    outs[n] = upd_pkg::PCT_CHAR;
                    n       = n + 1;
                    reopen  = 1'b1;
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (v != NOT_HEX) begin
                    hi        = hex_digit_value(dec_held);
                    outs[n]   = {hi[3:0], v[3:0]};
                    n         = n + 1;
                    dec_phase = upd_pkg::PH_IDLE;
                end else begin
                    // Broken escape: the percent sign and the held digit go out as they are.
                    outs[n]     = upd_pkg::PCT_CHAR;
                    outs[n + 1] = dec_held;
                    n           = n + 2;
                    reopen      = 1'b1;
                end
            end
            default: reopen = 1'b1;
        endcase
        if (reopen) begin
            if (c == upd_pkg::PCT_CHAR) begin
                dec_phase = upd_pkg::PH_PCT;
            end else begin
                dec_phase = upd_pkg::PH_IDLE;
                outs[n]   = c;
                n         = n + 1;
            end
        end
        if (last) begin
            // The string ends inside an escape: flush what was collected.
            if (dec_phase == upd_pkg::PH_PCT) begin
                outs[n] = upd_pkg::PCT_CHAR;
                n       = n + 1;
            end else if (dec_phase == upd_pkg::PH_DIGIT) begin
                outs[n]     = upd_pkg::PCT_CHAR;
                outs[n + 1] = dec_held;
                n           = n + 2;
            end
            dec_phase = upd_pkg::PH_IDLE;
            dec_held  = 8'h00;
        end
        for (int i = 0; i < n; i++) begin
            item.data     = outs[i];
            item.run_last = (i == n - 1);
            item.str_last = (i == n - 1) && last;
            decoded_q     = {decoded_q, item};
        end
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Compare every output transaction with the oldest predicted byte.
    always @(posedge i_clk) begin
        t_dec_out got;
        t_dec_out want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast};
            if (decoded_q.size() == 0) begin
                note_failure($sformatf("unexpected byte %02h user %0b last %0b",
                                       got.data, got.run_last, got.str_last));
            end else begin
                want = decoded_q.pop_front();
                if (got.data != want.data)
                    note_failure($sformatf("byte expected %02h actual %02h",
                                           want.data, got.data));
                if (got.run_last != want.run_last)
                    note_failure($sformatf("tuser expected %0b actual %0b (byte %02h)",
                                           want.run_last, got.run_last, want.data));
                if (got.str_last != want.str_last)
                    note_failure($sformatf("tlast expected %0b actual %0b (byte %02h)",
                                           want.str_last, got.str_last, want.data));
            end
        end
    end

    // Output sink: a random pause before each transaction when gaps are enabled, or a long hold when asked.
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (sink_hold_req > 0) begin
                gap           = sink_hold_req;
                sink_hold_req = 0;
            end else begin
                gap = gaps_enabled ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(o_m_axis_tvalid && i_m_axis_tready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    // tvalid stays high so that a following byte can go out without a bubble.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= last;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_decode(c, last);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // Stop offering input, let every predicted byte come out, then keep watching the
    // idle output so that a stray extra byte would still be caught.
    task automatic wait_drained();
        int waited;
        waited          = 0;
        i_s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > DRAIN_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return CH_0 + 8'(v);
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_digit_value(c) != NOT_HEX) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Extreme byte values and a one-byte string.
    task automatic test_plain_bytes();
        gaps_enabled = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("z", 1'b1);
        send_byte(8'h7F, 1'b1);
        wait_drained();
    endtask

    // Well-formed escapes with digits and letters of both cases.
    task automatic test_good_escapes();
        gaps_enabled = 1'b1;
        send_text("%0a%FF%Bc");
        send_text("%00");
        wait_drained();
    endtask

    // Escapes broken by a non-hex byte, by a second percent sign, and by a byte
    // that breaks after one digit and releases three bytes at once.
    task automatic test_broken_escapes();
        gaps_enabled = 1'b0;
        send_text("%G%4%%4x");
        wait_drained();
    endtask

    // Strings that end inside an escape, right after the percent sign or one digit.
    task automatic test_cut_by_end();
        gaps_enabled = 1'b1;
        send_text("%");
        send_text("%7");
        send_text("a%");
        wait_drained();
    endtask

    // Random strings built mostly from well-formed escapes, with plain bytes,
    // broken escapes and stray percent signs mixed in.
    task automatic test_random_strings();
        logic [7:0] str[$];
        int         sent;
        int         tokens;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            str.delete();
            tokens = $urandom_range(1, MAX_STR_TOKENS);
            for (int t = 0; t < tokens; t++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        str = {str, upd_pkg::PCT_CHAR};
                        str = {str, random_hex_char()};
                        str = {str, random_hex_char()};
                    end
                    5, 6: str = {str, 8'($urandom_range(0, 255))};
                    7: begin
                        str = {str, upd_pkg::PCT_CHAR};
                        str = {str, random_non_hex()};
                    end
                    8: begin
                        str = {str, upd_pkg::PCT_CHAR};
                        str = {str, random_hex_char()};
                        str = {str, 8'($urandom_range(0, 255))};
                    end
                    default: str = {str, upd_pkg::PCT_CHAR};
                endcase
            end
            // Roughly one string in four runs with no pauses on either side.
            gaps_enabled = ($urandom_range(0, 3) != 0);
            foreach (str[i]) send_byte(str[i], i == str.size() - 1);
            sent += str.size();
        end
        wait_drained();
    endtask

    // The sink holds off for a long stretch while bytes keep arriving back to back,
    // so the internal queue fills and the input side has to stall.
    task automatic test_output_hold();
        gaps_enabled  = 1'b0;
        sink_hold_req = HOLD_CYCLES;
        for (int i = 0; i < FLOOD_ITEMS; i++) begin
            if (i % 4 == 3) send_byte(random_non_hex(), i == FLOOD_ITEMS - 1);
            else            send_byte(upd_pkg::PCT_CHAR, i == FLOOD_ITEMS - 1);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        dec_phase       = upd_pkg::PH_IDLE;
        dec_held        = 8'h00;
        fail_count      = 0;
        gaps_enabled    = 1'b0;
        sink_hold_req   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_bytes();
        test_good_escapes();
        test_broken_escapes();
        test_cut_by_end();
        test_output_hold();
        test_random_strings();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
